/* rtl/sha_pkg.sv */
// Shared types, constants and round functions for the SHA-256 hasher.
`timescale 1ns / 1ps

package sha_pkg;

    localparam logic [7:0] PAD_MARK   = 8'h80;
    localparam logic [5:0] LAST_POS   = 6'd63;
    localparam logic [5:0] LEN_POS    = 6'd56;
    localparam logic [5:0] LAST_ROUND = 6'd63;
    localparam logic [2:0] LAST_WORD  = 3'd7;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUND,
        ST_FOLD,
        ST_PAD,
        ST_EMIT
    } sha_state_t;

    // Control toward the block buffer / message schedule.
    typedef struct packed {
        logic       push;
        logic [7:0] push_byte;
        logic       shift;
    } sha_bctl_t;

    // Control toward the round unit.
    typedef struct packed {
        logic       round;
        logic       fold;
        logic       init;
        logic [5:0] rnd;
    } sha_rctl_t;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] big_sig0(input logic [31:0] x);
        big_sig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] big_sig1(input logic [31:0] x);
        big_sig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic logic [31:0] small_sig0(input logic [31:0] x);
        small_sig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] small_sig1(input logic [31:0] x);
        small_sig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    function automatic logic [31:0] iv_word(input logic [2:0] i);
        case (i)
            3'd0:    iv_word = 32'h6a09e667;
            3'd1:    iv_word = 32'hbb67ae85;
            3'd2:    iv_word = 32'h3c6ef372;
            3'd3:    iv_word = 32'ha54ff53a;
            3'd4:    iv_word = 32'h510e527f;
            3'd5:    iv_word = 32'h9b05688c;
            3'd6:    iv_word = 32'h1f83d9ab;
            default: iv_word = 32'h5be0cd19;
        endcase
    endfunction

    function automatic logic [31:0] round_k(input logic [5:0] t);
        case (t)
            6'd0:  round_k = 32'h428a2f98;  6'd1:  round_k = 32'h71374491;
            6'd2:  round_k = 32'hb5c0fbcf;  6'd3:  round_k = 32'he9b5dba5;
            6'd4:  round_k = 32'h3956c25b;  6'd5:  round_k = 32'h59f111f1;
            6'd6:  round_k = 32'h923f82a4;  6'd7:  round_k = 32'hab1c5ed5;
            6'd8:  round_k = 32'hd807aa98;  6'd9:  round_k = 32'h12835b01;
            6'd10: round_k = 32'h243185be;  6'd11: round_k = 32'h550c7dc3;
            6'd12: round_k = 32'h72be5d74;  6'd13: round_k = 32'h80deb1fe;
            6'd14: round_k = 32'h9bdc06a7;  6'd15: round_k = 32'hc19bf174;
            6'd16: round_k = 32'he49b69c1;  6'd17: round_k = 32'hefbe4786;
            6'd18: round_k = 32'h0fc19dc6;  6'd19: round_k = 32'h240ca1cc;
            6'd20: round_k = 32'h2de92c6f;  6'd21: round_k = 32'h4a7484aa;
            6'd22: round_k = 32'h5cb0a9dc;  6'd23: round_k = 32'h76f988da;
            6'd24: round_k = 32'h983e5152;  6'd25: round_k = 32'ha831c66d;
            6'd26: round_k = 32'hb00327c8;  6'd27: round_k = 32'hbf597fc7;
            6'd28: round_k = 32'hc6e00bf3;  6'd29: round_k = 32'hd5a79147;
            6'd30: round_k = 32'h06ca6351;  6'd31: round_k = 32'h14292967;
            6'd32: round_k = 32'h27b70a85;  6'd33: round_k = 32'h2e1b2138;
            6'd34: round_k = 32'h4d2c6dfc;  6'd35: round_k = 32'h53380d13;
            6'd36: round_k = 32'h650a7354;  6'd37: round_k = 32'h766a0abb;
            6'd38: round_k = 32'h81c2c92e;  6'd39: round_k = 32'h92722c85;
            6'd40: round_k = 32'ha2bfe8a1;  6'd41: round_k = 32'ha81a664b;
            6'd42: round_k = 32'hc24b8b70;  6'd43: round_k = 32'hc76c51a3;
            6'd44: round_k = 32'hd192e819;  6'd45: round_k = 32'hd6990624;
            6'd46: round_k = 32'hf40e3585;  6'd47: round_k = 32'h106aa070;
            6'd48: round_k = 32'h19a4c116;  6'd49: round_k = 32'h1e376c08;
            6'd50: round_k = 32'h2748774c;  6'd51: round_k = 32'h34b0bcb5;
            6'd52: round_k = 32'h391c0cb3;  6'd53: round_k = 32'h4ed8aa4a;
            6'd54: round_k = 32'h5b9cca4f;  6'd55: round_k = 32'h682e6ff3;
            6'd56: round_k = 32'h748f82ee;  6'd57: round_k = 32'h78a5636f;
            6'd58: round_k = 32'h84c87814;  6'd59: round_k = 32'h8cc70208;
            6'd60: round_k = 32'h90befffa;  6'd61: round_k = 32'ha4506ceb;
            6'd62: round_k = 32'hbef9a3f7;  default: round_k = 32'hc67178f2;
        endcase
    endfunction

endpackage

/* rtl/sha_in_if.sv */
// Input channel carrying message bytes and the end-of-message flag.
`timescale 1ns / 1ps

interface sha_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       byte_present;
    logic       end_of_message;

    modport source (output valid, output data_byte, output byte_present,
                    output end_of_message, input ready);
    modport sink (input valid, input data_byte, input byte_present,
                  input end_of_message, output ready);
endinterface

/* rtl/sha_out_if.sv */
// Output channel carrying the digest words.
`timescale 1ns / 1ps

interface sha_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;

    modport source (output valid, output digest_word, output word_index,
                    output last_word, input ready);
    modport sink (input valid, input digest_word, input word_index,
                  input last_word, output ready);
endinterface

/* rtl/sha256_hasher_top.sv */
// Top level of the byte-serial SHA-256 hasher.
`timescale 1ns / 1ps
// A message byte is taken in one transfer; the byte that fills a 64-byte block is
// followed by 64 rounds of the single round unit and a fold, with no input taken.
// An end-of-message item pushes 9 to 72 padding bytes at one per cycle, runs one
// or two compressions and offers eight digest words, one per cycle while ready.
// Reset loads the initial hash value and clears the length count; the block
// buffer holds no reset value and is always overwritten before it is used.

module sha256_hasher_top
(
    input  logic      clk,
    input  logic      rst_n,
    sha_in_if.sink    msg,
    sha_out_if.source dig
);

    sha_pkg::sha_bctl_t bctl;
    sha_pkg::sha_rctl_t rctl;
    logic [31:0]        w_cur;
    logic [31:0]        h_word;
    logic [2:0]         word_sel;

    sha_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .msg      (msg),
        .dig      (dig),
        .h_word   (h_word),
        .word_sel (word_sel),
        .bctl     (bctl),
        .rctl     (rctl)
    );

    sha_sched u_sched
    (
        .clk   (clk),
        .bctl  (bctl),
        .w_cur (w_cur)
    );

    sha_round u_round
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .rctl     (rctl),
        .w_cur    (w_cur),
        .word_sel (word_sel),
        .h_word   (h_word)
    );

endmodule

/* rtl/sha_sched.sv */
// Block buffer that packs bytes and then rolls out the message schedule.
`timescale 1ns / 1ps

module sha_sched
(
    input  logic              clk,
    input  sha_pkg::sha_bctl_t bctl,
    output logic [31:0]       w_cur
);

    logic [511:0] blk_reg;
    logic [511:0] blk_next;
    logic [31:0]  w_new;

    // The window holds W[t] .. W[t+15] with W[t] in the top word.
    assign w_cur = blk_reg[511:480];
    assign w_new = sha_pkg::small_sig1(blk_reg[63:32]) + blk_reg[223:192]
                 + sha_pkg::small_sig0(blk_reg[479:448]) + blk_reg[511:480];

    always_comb
    begin
        blk_next = blk_reg;
        if (bctl.push)
        begin
            blk_next = {blk_reg[503:0], bctl.push_byte};
        end
        else if (bctl.shift)
        begin
            blk_next = {blk_reg[479:0], w_new};
        end
    end

    always_ff @(posedge clk)
    begin
        blk_reg <= blk_next;
    end

endmodule

/* rtl/sha_round.sv */
// Shared compression round unit with the working and chaining registers.
`timescale 1ns / 1ps

module sha_round
(
    input  logic               clk,
    input  logic               rst_n,
    input  sha_pkg::sha_rctl_t rctl,
    input  logic [31:0]        w_cur,
    input  logic [2:0]         word_sel,
    output logic [31:0]        h_word
);

    logic [31:0] h_reg [0:7];
    logic [31:0] v_reg [0:7];
    logic [31:0] t1;
    logic [31:0] t2;
    logic [31:0] ch;
    logic [31:0] maj;

    assign ch  = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
    assign maj = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
    assign t1  = v_reg[7] + sha_pkg::big_sig1(v_reg[4]) + ch
               + sha_pkg::round_k(rctl.rnd) + w_cur;
    assign t2  = sha_pkg::big_sig0(v_reg[0]) + maj;

    assign h_word = h_reg[word_sel];

    // The working registers always equal the chaining value outside a
    // compression, so a compression starts without a separate load step.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 8; i++)
            begin
                h_reg[i] <= sha_pkg::iv_word(3'(i));
                v_reg[i] <= sha_pkg::iv_word(3'(i));
            end
        end
        else if (rctl.init)
        begin
            for (int i = 0; i < 8; i++)
            begin
                h_reg[i] <= sha_pkg::iv_word(3'(i));
                v_reg[i] <= sha_pkg::iv_word(3'(i));
            end
        end
        else if (rctl.fold)
        begin
            for (int i = 0; i < 8; i++)
            begin
                h_reg[i] <= h_reg[i] + v_reg[i];
                v_reg[i] <= h_reg[i] + v_reg[i];
            end
        end
        else if (rctl.round)
        begin
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
        end
    end

endmodule

/* rtl/sha_ctrl.sv */
// Sequencer: byte intake, padding, round counting and digest output.
`timescale 1ns / 1ps

module sha_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    sha_in_if.sink             msg,
    sha_out_if.source          dig,
    input  logic [31:0]        h_word,
    output logic [2:0]         word_sel,
    output sha_pkg::sha_bctl_t bctl,
    output sha_pkg::sha_rctl_t rctl
);

    sha_pkg::sha_state_t state_reg, state_next;
    logic [5:0]  pos_reg, pos_next;
    logic [60:0] cnt_reg, cnt_next;
    logic [5:0]  rnd_reg, rnd_next;
    logic [2:0]  idx_reg, idx_next;
    logic        eom_reg, eom_next;
    logic        mark_reg, mark_next;
    logic        len_reg, len_next;
    logic        final_reg, final_next;
    logic [63:0] len_bits;
    logic [5:0]  len_shift;
    logic        is_len;

    assign len_bits  = {cnt_reg, 3'b000};
    assign len_shift = {~pos_reg[2:0], 3'b000};
    assign is_len    = mark_reg && (pos_reg == sha_pkg::LEN_POS || len_reg);

    assign word_sel        = idx_reg;
    assign dig.digest_word = h_word;
    assign dig.word_index  = idx_reg;
    assign dig.last_word   = (idx_reg == sha_pkg::LAST_WORD);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sha_pkg::ST_IDLE;
            pos_reg   <= '0;
            cnt_reg   <= '0;
            rnd_reg   <= '0;
            idx_reg   <= '0;
            eom_reg   <= 1'b0;
            mark_reg  <= 1'b0;
            len_reg   <= 1'b0;
            final_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
            cnt_reg   <= cnt_next;
            rnd_reg   <= rnd_next;
            idx_reg   <= idx_next;
            eom_reg   <= eom_next;
            mark_reg  <= mark_next;
            len_reg   <= len_next;
            final_reg <= final_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        cnt_next       = cnt_reg;
        rnd_next       = rnd_reg;
        idx_next       = idx_reg;
        eom_next       = eom_reg;
        mark_next      = mark_reg;
        len_next       = len_reg;
        final_next     = final_reg;
        msg.ready      = 1'b0;
        dig.valid      = 1'b0;
        bctl.push      = 1'b0;
        bctl.push_byte = '0;
        bctl.shift     = 1'b0;
        rctl.round     = 1'b0;
        rctl.fold      = 1'b0;
        rctl.init      = 1'b0;
        rctl.rnd       = rnd_reg;

        unique case (state_reg)
            sha_pkg::ST_IDLE:
            begin
                msg.ready = 1'b1;
                if (msg.valid)
                begin
                    eom_next = msg.end_of_message;
                    if (msg.byte_present)
                    begin
                        bctl.push      = 1'b1;
                        bctl.push_byte = msg.data_byte;
                        pos_next       = pos_reg + 6'd1;
                        cnt_next       = cnt_reg + 61'd1;
                    end
                    // A byte that fills the block is compressed before any padding.
                    if (msg.byte_present && pos_reg == sha_pkg::LAST_POS)
                    begin
                        rnd_next   = '0;
                        state_next = sha_pkg::ST_ROUND;
                    end
                    else if (msg.end_of_message)
                    begin
                        state_next = sha_pkg::ST_PAD;
                    end
                end
            end

            sha_pkg::ST_ROUND:
            begin
                bctl.shift = 1'b1;
                rctl.round = 1'b1;
                rnd_next   = rnd_reg + 6'd1;
                if (rnd_reg == sha_pkg::LAST_ROUND)
                begin
                    state_next = sha_pkg::ST_FOLD;
                end
            end

            sha_pkg::ST_FOLD:
            begin
                rctl.fold = 1'b1;
                if (final_reg)
                begin
                    idx_next   = '0;
                    state_next = sha_pkg::ST_EMIT;
                end
                else if (eom_reg)
                begin
                    state_next = sha_pkg::ST_PAD;
                end
                else
                begin
                    state_next = sha_pkg::ST_IDLE;
                end
            end

            sha_pkg::ST_PAD:
            begin
                bctl.push = 1'b1;
                pos_next  = pos_reg + 6'd1;
                if (!mark_reg)
                begin
                    bctl.push_byte = sha_pkg::PAD_MARK;
                    mark_next      = 1'b1;
                end
                else if (is_len)
                begin
                    bctl.push_byte = len_bits[len_shift +: 8];
                    len_next       = 1'b1;
                end
                if (pos_reg == sha_pkg::LAST_POS)
                begin
                    final_next = is_len;
                    rnd_next   = '0;
                    state_next = sha_pkg::ST_ROUND;
                end
            end

            sha_pkg::ST_EMIT:
            begin
                dig.valid = 1'b1;
                if (dig.ready)
                begin
                    idx_next = idx_reg + 3'd1;
                    if (idx_reg == sha_pkg::LAST_WORD)
                    begin
                        rctl.init  = 1'b1;
                        cnt_next   = '0;
                        pos_next   = '0;
                        eom_next   = 1'b0;
                        mark_next  = 1'b0;
                        len_next   = 1'b0;
                        final_next = 1'b0;
                        state_next = sha_pkg::ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = sha_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

/* rtl/sha_checker.sv */
// Port-level checks for the SHA-256 hasher and their binding to the top level.
`timescale 1ns / 1ps

module sha_checker
(
    input  logic      clk,
    input  logic      rst_n,
    sha_in_if.sink    msg,
    sha_out_if.source dig
);

    // Input intake and digest output never overlap.
    assert property (@(posedge clk) disable iff (!rst_n)
        msg.ready |-> !dig.valid)
        else $error("input ready while a digest word is offered");

    // A stalled digest word keeps its index.
    assert property (@(posedge clk) disable iff (!rst_n)
        dig.valid && !dig.ready |=> dig.valid && $stable(dig.word_index))
        else $error("digest word index changed under stall");

    // Words of one digest follow each other in order.
    assert property (@(posedge clk) disable iff (!rst_n)
        dig.valid && dig.ready && !dig.last_word |=>
            dig.valid && dig.word_index == $past(dig.word_index) + 3'd1)
        else $error("digest words out of order");

    // The last flag marks the eighth word only.
    assert property (@(posedge clk) disable iff (!rst_n)
        dig.valid |-> dig.last_word == (dig.word_index == 3'd7))
        else $error("last word flag mismatch");

    // After the last word the block takes input again.
    assert property (@(posedge clk) disable iff (!rst_n)
        dig.valid && dig.ready && dig.last_word |=> !dig.valid && msg.ready)
        else $error("block not idle after digest");

endmodule

bind sha256_hasher_top sha_checker u_checker
(
    .clk   (clk),
    .rst_n (rst_n),
    .msg   (msg),
    .dig   (dig)
);
